// ===== hdl/barc_pkg.sv =====
package barc_pkg;

   localparam int FRAME_RATE = 60;

   localparam int WRAP_W    = 9;
   localparam int DELAY_W   = 8;
   localparam int CURSOR_W  = 8;
   localparam int SUBMODE_W = 8;
   localparam int FRAME_W   = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_AW    = 3;

   localparam logic [WRAP_W-1:0]    WRAP_RESET    = 9'd256;
   localparam logic [WRAP_W-1:0]    WRAP_MAX      = 9'd256;
   localparam logic [DELAY_W-1:0]   DELAY_RESET   = DELAY_W'((FRAME_RATE / 2) % 256);
   localparam logic [SUBMODE_W-1:0] SUBMODE_RESET = 8'd255;

   typedef enum logic {
      REG_WRAP_SIZE     = 1'b0,
      REG_REPEAT_DELAY  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic                 button_up;
      logic                 button_down;
      logic [SUBMODE_W-1:0] submode;
      logic [FRAME_W-1:0]   frame_number;
   } item_type;

   typedef struct packed {
      logic [WRAP_W-1:0]  wrap_size;
      logic [DELAY_W-1:0] repeat_delay;
   } cfg_type;

endpackage

// ===== hdl/barc_core.sv =====
module barc_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  barc_pkg::item_type               item,
   input  barc_pkg::cfg_type                cfg,
   input  logic                             clear_cursor,
   output logic [barc_pkg::CURSOR_W-1:0]    cursor_next
);
   import barc_pkg::*;

   logic                 prev_up_ff, prev_up_in;
   logic                 prev_down_ff, prev_down_in;
   logic [SUBMODE_W-1:0] seen_submode_ff, seen_submode_in;
   logic [CURSOR_W-1:0]  cursor_ff, cursor_in;
   logic [FRAME_W-1:0]   start_frame_ff, start_frame_in;

   logic                 up_edge, down_edge, up_only, down_only, repeat_due;
   logic [CURSOR_W-1:0]  base;
   logic [WRAP_W-1:0]    wrap_eff, inc;
   logic [FRAME_W-1:0]   held;

   always_comb begin
      up_edge   = item.button_up != prev_up_ff;
      down_edge = item.button_down != prev_down_ff;
      up_only   = item.button_up & ~item.button_down;
      down_only = item.button_down & ~item.button_up;

      // wrap of zero behaves as one, anything past 256 as 256
      if (cfg.wrap_size == '0) begin
         wrap_eff = WRAP_W'(1);
      end else if (cfg.wrap_size > WRAP_MAX) begin
         wrap_eff = WRAP_MAX;
      end else begin
         wrap_eff = cfg.wrap_size;
      end

      base = (item.submode != seen_submode_ff) ? '0 : cursor_ff;
      held = item.frame_number - start_frame_ff;
      repeat_due = (held > FRAME_W'(cfg.repeat_delay)) && !held[0];
      inc = {1'b0, base} + WRAP_W'(1);

      start_frame_in = start_frame_ff;
      if ((up_only && up_edge) || (down_only && down_edge)) begin
         start_frame_in = item.frame_number;
      end

      // cursor stays below wrap_eff, so wrapping is a single compare
      if (up_only && (up_edge || repeat_due)) begin
         cursor_next = (inc == wrap_eff) ? '0 : inc[CURSOR_W-1:0];
      end else if (down_only && (down_edge || repeat_due)) begin
         cursor_next = (base == '0) ? CURSOR_W'(wrap_eff - WRAP_W'(1))
                                    : base - CURSOR_W'(1);
      end else begin
         cursor_next = base;
      end

      prev_up_in      = item.button_up;
      prev_down_in    = item.button_down;
      seen_submode_in = item.submode;
      cursor_in       = cursor_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_up_ff      <= 1'b0;
         prev_down_ff    <= 1'b0;
         seen_submode_ff <= SUBMODE_RESET;
         cursor_ff       <= '0;
         start_frame_ff  <= '0;
      end else if (fire) begin
         prev_up_ff      <= prev_up_in;
         prev_down_ff    <= prev_down_in;
         seen_submode_ff <= seen_submode_in;
         cursor_ff       <= cursor_in;
         start_frame_ff  <= start_frame_in;
      end else if (clear_cursor) begin
         cursor_ff <= '0;
      end
   end

endmodule

// ===== hdl/button_auto_repeat_cursor.sv =====
// Button auto-repeat cursor.
//
// Request channel (req_*): one transaction per display frame carrying the two
// button levels, the submode number and the running frame count. Response
// channel (rsp_*): one transaction per request with the cursor after that
// frame, in request order. Both use valid/ready.
//
// An accepted request waits in the request register until the step logic
// fires and writes its cursor to the two-entry response buffer (output
// register plus skid register). Throughput is one transaction per cycle while
// the receiver keeps up. The cursor state updates in the same cycle the step
// logic fires, so each frame sees the state left by the last.
//
// When the receiver stalls, the request register still drains into the skid
// register; req_ready drops only once both response entries and the request
// register are full. Reset empties all buffers, sets cursor 0, the last seen
// submode to 255, the wrap to 256 and the repeat delay to 30 frames.
// CSR (APB-style, zero wait states): 0x0 wrap size (a write clears the
// cursor), 0x4 repeat_delay_frames. Write only while the block is idle.
module button_auto_repeat_cursor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_button_up,
   input  logic                              req_button_down,
   input  logic [barc_pkg::SUBMODE_W-1:0]    req_submode,
   input  logic [barc_pkg::FRAME_W-1:0]      req_frame_number,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [barc_pkg::CURSOR_W-1:0]     rsp_cursor,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [barc_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [barc_pkg::CSR_W-1:0]        csr_pwdata,
   output logic [barc_pkg::CSR_W-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import barc_pkg::*;

   // configuration registers
   cfg_type       cfg_ff;
   logic          csr_write;
   reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_size    <= WRAP_RESET;
         cfg_ff.repeat_delay <= DELAY_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_WRAP_SIZE:    cfg_ff.wrap_size    <= csr_pwdata[WRAP_W-1:0];
            REG_REPEAT_DELAY: cfg_ff.repeat_delay <= csr_pwdata[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WRAP_SIZE:    csr_prdata = CSR_W'(cfg_ff.wrap_size);
         REG_REPEAT_DELAY: csr_prdata = CSR_W'(cfg_ff.repeat_delay);
         default:          csr_prdata = '0;
      endcase
   end

   // request register
   logic     s1_valid_ff;
   item_type s1_item_ff;
   logic     fire, req_take;

   // response buffer: head register drives the port, skid catches a stall
   logic                rsp_valid_ff, skid_valid_ff, pop;
   logic [CURSOR_W-1:0] rsp_cursor_ff, skid_cursor_ff, cursor_next;

   assign pop       = rsp_valid_ff & rsp_ready;
   assign fire      = s1_valid_ff & ~skid_valid_ff;
   assign req_ready = ~s1_valid_ff | fire;
   assign req_take  = req_valid & req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_take) begin
         s1_item_ff.button_up    <= req_button_up;
         s1_item_ff.button_down  <= req_button_down;
         s1_item_ff.submode      <= req_submode;
         s1_item_ff.frame_number <= req_frame_number;
      end
   end

   barc_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (s1_item_ff),
      .cfg          (cfg_ff),
      .clear_cursor (csr_write && csr_index == REG_WRAP_SIZE),
      .cursor_next  (cursor_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (pop) begin
         if (skid_valid_ff) begin
            // fire is low while the skid is full
            rsp_cursor_ff <= skid_cursor_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= fire;
            rsp_cursor_ff <= cursor_next;
         end
      end else if (fire) begin
         if (!rsp_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            rsp_cursor_ff <= cursor_next;
         end else begin
            skid_valid_ff  <= 1'b1;
            skid_cursor_ff <= cursor_next;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_cursor = rsp_cursor_ff;

endmodule

// ===== hdl/barc_checker.sv =====
module barc_port_asserts (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [barc_pkg::CURSOR_W-1:0] rsp_cursor
);
   import barc_pkg::*;

   // requests accepted and not yet answered
   logic [2:0] pending_ff, pending_in;

   always_comb begin
      pending_in = pending_ff + 3'(req_valid & req_ready) - 3'(rsp_valid & rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assert_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor))
      else $error("stalled response changed");

   assert_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response without an outstanding request");

   assert_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("more requests in flight than the buffers hold");

endmodule

bind button_auto_repeat_cursor barc_port_asserts u_barc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_cursor (rsp_cursor)
);

// ===== tb/barc_checker.sv =====
module barc_checker
   import barc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_button_up,
   input  logic                 req_button_down,
   input  logic [SUBMODE_W-1:0] req_submode,
   input  logic [FRAME_W-1:0]   req_frame_number,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [CURSOR_W-1:0]  rsp_cursor,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_W-1:0]     csr_pwdata,
   input  logic                 csr_pready,
   output int                   error_count,
   output int                   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow registers
   logic [WRAP_W-1:0]    wrap_reg;
   logic [DELAY_W-1:0]   delay_reg;

   // shadow cursor state
   logic                 held_up;
   logic                 held_down;
   logic [SUBMODE_W-1:0] last_submode;
   int                   cursor_pos;
   logic [FRAME_W-1:0]   press_frame;

   logic [CURSOR_W-1:0]  cursor_queue[$];

   function automatic int wrap_span(input logic [WRAP_W-1:0] w);
      if (w == '0) return 1;
      if (w > WRAP_MAX) return 256;
      return int'(w);
   endfunction

   task automatic advance_cursor(input logic up, input logic down,
                                 input logic [SUBMODE_W-1:0] sub,
                                 input logic [FRAME_W-1:0] frame,
                                 output logic [CURSOR_W-1:0] cursor);
      logic               up_edge;
      logic               down_edge;
      logic               edge_seen;
      logic               due;
      logic [FRAME_W-1:0] held;
      int                 span;
      up_edge   = up != held_up;
      down_edge = down != held_down;
      span      = wrap_span(wrap_reg);
      held_up   = up;
      held_down = down;
      if (sub != last_submode) begin
         cursor_pos   = 0;
         last_submode = sub;
      end
      if (up != down) begin
         // only the edge of the held button restarts the repeat timer
         edge_seen = up ? up_edge : down_edge;
         held      = frame - press_frame;
         if (edge_seen) begin
            press_frame = frame;
            due         = 1'b1;
         end else begin
            due = (held > FRAME_W'(delay_reg)) && !held[0];
         end
         if (due) cursor_pos += up ? 1 : span - 1;
      end
      cursor_pos = cursor_pos % span;
      cursor     = CURSOR_W'(cursor_pos);
   endtask

   always @(posedge clock) begin
      logic [CURSOR_W-1:0] predicted;
      logic [CURSOR_W-1:0] wanted;
      if (reset) begin
         wrap_reg     = WRAP_RESET;
         delay_reg    = DELAY_RESET;
         held_up      = 1'b0;
         held_down    = 1'b0;
         last_submode = SUBMODE_RESET;
         cursor_pos   = 0;
         press_frame  = '0;
         cursor_queue.delete();
         error_count  = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_AW-1:2])
               REG_WRAP_SIZE: begin
                  wrap_reg   = csr_pwdata[WRAP_W-1:0];
                  cursor_pos = 0;
               end
               REG_REPEAT_DELAY: begin
                  delay_reg = csr_pwdata[DELAY_W-1:0];
               end
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_cursor(req_button_up, req_button_down, req_submode,
                           req_frame_number, predicted);
            cursor_queue.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (cursor_queue.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: cursor %0d returned with no frame outstanding",
                           $realtime, rsp_cursor);
            end else begin
               wanted = cursor_queue.pop_front();
               if (rsp_cursor !== wanted) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("%0t: cursor mismatch, expected %0d, got %0d",
                              $realtime, wanted, rsp_cursor);
               end
            end
         end
      end
      pending_results = cursor_queue.size();
   end

endmodule

// ===== tb/tb_button_auto_repeat_cursor.sv =====
module tb_button_auto_repeat_cursor;
   import barc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles without any accepted transaction before the run is abandoned
   localparam int WATCHDOG_LIMIT = 2000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_button_up = 1'b0;
   logic                 req_button_down = 1'b0;
   logic [SUBMODE_W-1:0] req_submode = '0;
   logic [FRAME_W-1:0]   req_frame_number = '0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CURSOR_W-1:0]  rsp_cursor;

   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]    csr_paddr = '0;
   logic [CSR_W-1:0]     csr_pwdata = '0;
   logic [CSR_W-1:0]     csr_prdata;
   logic                 csr_pready;

   int                   error_count;
   int                   pending_results;

   // pacing knobs, percent of cycles
   int                   sender_idle_pct = 0;
   int                   receiver_stall_pct = 0;

   int                   frames_sent = 0;
   int                   settings_applied = 0;
   int                   quiet_cycles = 0;

   always #10 clock = ~clock;

   button_auto_repeat_cursor dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_up    (req_button_up),
      .req_button_down  (req_button_down),
      .req_submode      (req_submode),
      .req_frame_number (req_frame_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cursor       (rsp_cursor),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   barc_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_button_up    (req_button_up),
      .req_button_down  (req_button_down),
      .req_submode      (req_submode),
      .req_frame_number (req_frame_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_cursor       (rsp_cursor),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .error_count      (error_count),
      .pending_results  (pending_results)
   );

   // Receiver: ready is redrawn every falling edge from the current stall rate.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog: any accepted transaction (request, response or register
   // access) clears the count. Outputs are read right after the edge, before
   // the DUT's own updates land.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Called at a falling edge, returns at a falling edge with the frame taken.
   // Idle gaps drop valid; once raised, valid and payload hold until accepted.
   task automatic send_frame(input logic up, input logic down,
                             input logic [SUBMODE_W-1:0] sub,
                             input logic [FRAME_W-1:0] frame);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_button_up    <= up;
      req_button_down  <= down;
      req_submode      <= sub;
      req_frame_number <= frame;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      frames_sent++;
   endtask

   // Two-phase register write: setup, then access, then back to idle;
   // pready is honored even though the block never inserts wait states.
   task automatic write_register(input reg_index_type idx, input logic [CSR_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Drain all outstanding cursors, then let the pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Registers change only with the block idle. Upper data bits are random so
   // that field masking is exercised too.
   task automatic apply_settings(input logic [WRAP_W-1:0] wrap,
                                 input logic [DELAY_W-1:0] delay);
      wait_drained();
      write_register(REG_WRAP_SIZE, {$urandom} & ~32'h1FF | CSR_W'(wrap));
      write_register(REG_REPEAT_DELAY, {$urandom} & ~32'hFF | CSR_W'(delay));
      settings_applied++;
   endtask

   // Random button sessions: a chosen combination is held over a run of
   // mostly consecutive frames so the repeat timer gets past the delay.
   // Frame jumps, submode changes and stray button frames are mixed in.
   task automatic play_sessions(input int count);
      logic [FRAME_W-1:0]   frame;
      logic [SUBMODE_W-1:0] sub;
      logic                 up;
      logic                 down;
      int                   combo;
      int                   hold;
      int                   roll;
      int                   sent;
      frame = $urandom;
      sub   = SUBMODE_W'($urandom_range(255));
      sent  = 0;
      while (sent < count) begin
         combo = $urandom_range(99);
         up    = (combo < 40) || (combo >= 80 && combo < 90);
         down  = (combo >= 40 && combo < 90);
         hold  = $urandom_range(1, 48);
         for (int k = 0; k < hold && sent < count; k++) begin
            if ($urandom_range(99) < 3) sub = SUBMODE_W'($urandom_range(255));
            roll = $urandom_range(99);
            if (roll < 88)
               frame = frame + 1;
            else if (roll < 97)
               frame = frame + $urandom_range(2, 300);
            else
               frame = $urandom;
            if ($urandom_range(99) < 4)
               send_frame(1'($urandom_range(1)), 1'($urandom_range(1)), sub, frame);
            else
               send_frame(up, down, sub, frame);
            sent++;
         end
      end
   endtask

   int wrap_plan[8]   = '{256, 1, 511, 10, 0, 2, 200, 37};
   int delay_plan[8]  = '{0, 5, 255, 2, 30, 1, 7, 12};
   int idle_plan[4]   = '{0, 63, 0, 35};
   int stall_plan[4]  = '{0, 0, 63, 35};

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed frames, reset settings: wrap 256, delay 30 ----
      send_frame(0, 0, 8'd0, 32'd0);            // submode change from 255 clears
      send_frame(1, 0, 8'd0, 32'd1);            // up press edge: step
      send_frame(1, 0, 8'd0, 32'd31);           // held exactly the delay: no step
      send_frame(1, 0, 8'd0, 32'd32);           // past delay, odd offset: no step
      send_frame(1, 0, 8'd0, 32'd33);           // past delay, even offset: step
      send_frame(1, 1, 8'd0, 32'd34);           // both held: no step
      // down released while up held: up timer keeps its original start
      send_frame(1, 0, 8'd0, 32'd35);
      send_frame(0, 0, 8'd0, 32'd36);
      send_frame(0, 1, 8'd0, 32'hFFFF_FFF0);    // down press near frame wrap
      send_frame(0, 1, 8'd0, 32'h0000_0020);    // hold spans the frame count wrap
      send_frame(0, 1, 8'd0, 32'h0000_0022);
      send_frame(0, 1, 8'd0, 32'h0000_0024);    // steps below zero, wraps to 255
      send_frame(0, 1, 8'd255, 32'h0000_0026);  // new submode clears, then steps
      send_frame(0, 0, 8'd255, 32'hFFFF_FFFF);

      // wrap of zero behaves as one position
      apply_settings(9'd0, 8'd30);
      send_frame(1, 0, 8'd255, 32'd5);
      send_frame(0, 1, 8'd255, 32'd6);

      // wrap above 256 saturates, zero delay repeats on every even offset
      apply_settings(9'd511, 8'd0);
      send_frame(1, 0, 8'd255, 32'd100);
      send_frame(1, 0, 8'd255, 32'd101);
      send_frame(1, 0, 8'd255, 32'd102);
      send_frame(0, 0, 8'd255, 32'd103);
      send_frame(0, 1, 8'd255, 32'd104);
      send_frame(0, 1, 8'd255, 32'd106);

      // longest delay with the smallest useful wrap
      apply_settings(9'd2, 8'd255);
      send_frame(1, 0, 8'd7, 32'd1000);
      send_frame(1, 0, 8'd7, 32'd1255);         // held 255: not yet
      send_frame(1, 0, 8'd7, 32'd1256);         // held 256: step, wraps to 0

      // ---- random sessions: four pacing phases, two settings each ----
      for (int phase = 0; phase < 4; phase++) begin
         for (int s = 0; s < 2; s++) begin
            apply_settings(WRAP_W'(wrap_plan[2*phase+s]),
                           DELAY_W'(delay_plan[2*phase+s]));
            sender_idle_pct    = idle_plan[phase];
            receiver_stall_pct = stall_plan[phase];
            play_sessions(135);
            sender_idle_pct    = 0;
         end
      end

      // let the receiver drain freely, then allow for pipeline latency
      receiver_stall_pct = 0;
      wait_drained();
      repeat (10) @(negedge clock);

      $display("Sent %0d frames under %0d register settings;", frames_sent,
               settings_applied);
      $display("pacing ran from back-to-back to 63 percent idle/stall per side.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== button_auto_repeat_cursor.f =====
hdl/barc_pkg.sv
hdl/barc_core.sv
hdl/button_auto_repeat_cursor.sv
hdl/barc_checker.sv
tb/barc_checker.sv
tb/tb_button_auto_repeat_cursor.sv
